### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the counting sort block.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every rising clock edge outside of reset.
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

### rtl/core/cso_pkg.sv
// Package of the counting sort block: field widths, commands, count store operations.
// Used by cso_level_counter, counting_sort_descending and the testbench; depends on nothing else.
package cso_pkg;

    localparam int KEY_W         = 9;
    localparam int TAG_W         = 12;
    localparam int REC_W         = KEY_W + TAG_W;
    localparam int TDATA_W       = ((REC_W + 7) / 8) * 8;
    localparam int RECORDS_DEF   = 4096;
    localparam int GRADE_MAX_DEF = 100;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [1:0] {
        CNT_CLEAR,
        CNT_INC,
        CNT_DEC,
        CNT_PREFIX
    } cnt_op_t;

    typedef struct packed {
        logic    valid;
        cnt_op_t op;
    } cnt_req_t;

endpackage

### rtl/core/cso_level_counter.sv
// Level count store of the counting sort with a read-modify-write pipeline.
// Depends on cso_pkg for the operation codes and the request struct.
module cso_level_counter #(
    parameter int LEVELS = 301,
    parameter int CNT_W  = 13,
    localparam int LVL_W = $clog2(LEVELS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cso_pkg::cnt_req_t     req,
    input  logic [LVL_W-1:0]      addr,
    output cso_pkg::cnt_req_t     upd,
    output logic [CNT_W-1:0]      value
);
    import cso_pkg::*;

    logic [CNT_W-1:0] cnt_mem [LEVELS];
    logic [CNT_W-1:0] rd_data_reg;
    logic             s1_valid_reg;
    cnt_op_t          s1_op_reg;
    logic [LVL_W-1:0] s1_addr_reg;
    logic             byp_reg;
    logic [CNT_W-1:0] byp_val_reg;
    logic [CNT_W-1:0] acc_reg;
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] acc_in;
    logic [CNT_W-1:0] new_val;

    // The previous request writes at the same edge at which this one reads,
    // so its result is forwarded when both hit the same level.
    assign base   = byp_reg ? byp_val_reg : rd_data_reg;
    assign acc_in = (s1_addr_reg == '0) ? '0 : acc_reg;

    always_comb
    begin
        case (s1_op_reg)
            CNT_INC:    new_val = base + CNT_W'(1);
            CNT_DEC:    new_val = base - CNT_W'(1);
            CNT_PREFIX: new_val = acc_in + base;
            CNT_CLEAR:  new_val = '0;
            default:    new_val = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            rd_data_reg <= cnt_mem[addr];
        end
        if (s1_valid_reg)
        begin
            cnt_mem[s1_addr_reg] <= new_val;
            acc_reg              <= new_val;
        end
        s1_op_reg   <= req.op;
        s1_addr_reg <= addr;
        byp_reg     <= s1_valid_reg && (s1_addr_reg == addr);
        byp_val_reg <= new_val;
    end

    assign upd.valid = s1_valid_reg;
    assign upd.op    = s1_op_reg;
    assign value     = new_val;

endmodule

### rtl/core/counting_sort_descending.sv
// Counting sort of tagged records by key, descending. Load transfers (tuser 0) write one record
// each at one per cycle while tready is high and count its key on the way in; keys above
// 3*GRADE_MAX saturate and loads beyond RECORDS are dropped. The load with tlast set starts the
// sort, during which tready is low: one pass over the level count store forms the running sum,
// one pass over the record store places the records, and one more pass clears the count store.
// After reset the same clearing pass runs before the first transfer is taken. Read transfers
// (tuser 1) then return one result each at one per cycle while m_axis_tready stays high,
// highest key first, with equal keys in reverse load order; a result passes through a pending
// register and then the output register. A read with no record left returns tuser 1 and zero
// data. Depends on cso_pkg, cso_level_counter and assert_macros.svh.
`include "assert_macros.svh"

module counting_sort_descending #(
    parameter int RECORDS   = cso_pkg::RECORDS_DEF,
    parameter int GRADE_MAX = cso_pkg::GRADE_MAX_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // Fields from bit 0: sort_key, record_tag, zero padding.
    input  logic [cso_pkg::TDATA_W-1:0]  s_axis_tdata,
    input  logic                         s_axis_tlast,
    // Fields from bit 0: cmd.
    input  logic                         s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // Fields from bit 0: out_tag, out_key, zero padding.
    output logic [cso_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic                         m_axis_tlast,
    // Fields from bit 0: none_left.
    output logic                         m_axis_tuser
);
    import cso_pkg::*;

    localparam int TOP_LEVEL = 3 * GRADE_MAX;
    localparam int LEVELS    = TOP_LEVEL + 1;
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int CNT_W     = $clog2(RECORDS + 1);
    localparam int IDX_W     = $clog2(RECORDS);

    typedef enum logic [2:0] {
        ST_INIT_CLR,
        ST_LOAD,
        ST_PREFIX,
        ST_PLACE,
        ST_SORT_CLR,
        ST_READ
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] loaded_reg, loaded_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic [IDX_W-1:0] src_reg, src_next;
    logic             pl_b_valid_reg, pl_b_valid_next;
    logic             p_valid_reg, p_valid_next;
    logic             p_none_reg, p_none_next;
    logic             p_end_reg, p_end_next;
    logic             out_valid_reg, out_valid_next;

    logic [REC_W-1:0] rec_mem [RECORDS];
    logic [REC_W-1:0] srt_mem [RECORDS];
    logic [REC_W-1:0] rec_rdata_reg;
    logic [REC_W-1:0] srt_rdata_reg;
    logic [REC_W-1:0] pl_c_data_reg;
    logic [REC_W-1:0] out_data_reg;
    logic             out_last_reg;
    logic             out_none_reg;

    logic             in_xfer, ld_xfer, rd_xfer;
    logic             in_read, full, ld_store, rd_avail;
    logic             p_move, p_block;
    logic [KEY_W-1:0] ld_key, ld_key_sat;
    logic [TAG_W-1:0] ld_tag;
    logic [CNT_W-1:0] ld_base;
    logic [CNT_W-1:0] rd_pos;
    logic             lvl_last;

    cnt_req_t         cnt_req;
    logic [LVL_W-1:0] cnt_addr;
    cnt_req_t         cnt_upd;
    logic [CNT_W-1:0] cnt_value;

    assign ld_key     = s_axis_tdata[KEY_W-1:0];
    assign ld_tag     = s_axis_tdata[REC_W-1:KEY_W];
    assign ld_key_sat = (32'(ld_key) > TOP_LEVEL) ? KEY_W'(TOP_LEVEL) : ld_key;

    assign p_move  = p_valid_reg && (!out_valid_reg || m_axis_tready);
    assign p_block = p_valid_reg && !p_move;

    assign s_axis_tready = ((state_reg == ST_LOAD) || (state_reg == ST_READ)) && !p_block;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign ld_xfer  = in_xfer && (s_axis_tuser == CMD_LOAD);
    assign rd_xfer  = in_xfer && (s_axis_tuser == CMD_READ);
    assign in_read  = (state_reg == ST_READ);
    assign full     = !in_read && (loaded_reg == CNT_W'(RECORDS));
    assign ld_store = ld_xfer && !full;
    assign ld_base  = in_read ? '0 : loaded_reg;
    assign rd_avail = in_read && (remain_reg != '0);
    assign rd_pos   = remain_reg - CNT_W'(1);
    assign lvl_last = (lvl_reg == LVL_W'(TOP_LEVEL));

    function automatic logic [IDX_W-1:0] rd_pos_of_loaded(input logic [CNT_W-1:0] count);
        logic [CNT_W-1:0] last_pos;
        last_pos = count - CNT_W'(1);
        return last_pos[IDX_W-1:0];
    endfunction

    always_comb
    begin
        cnt_req.valid = 1'b0;
        cnt_req.op    = CNT_CLEAR;
        cnt_addr      = lvl_reg;
        if (ld_store)
        begin
            cnt_req.valid = 1'b1;
            cnt_req.op    = CNT_INC;
            cnt_addr      = LVL_W'(ld_key_sat);
        end
        else if (pl_b_valid_reg)
        begin
            cnt_req.valid = 1'b1;
            cnt_req.op    = CNT_DEC;
            cnt_addr      = LVL_W'(rec_rdata_reg[REC_W-1:TAG_W]);
        end
        else if (state_reg == ST_PREFIX)
        begin
            cnt_req.valid = 1'b1;
            cnt_req.op    = CNT_PREFIX;
        end
        else if ((state_reg == ST_INIT_CLR) || (state_reg == ST_SORT_CLR))
        begin
            cnt_req.valid = 1'b1;
            cnt_req.op    = CNT_CLEAR;
        end
    end

    cso_level_counter #(
        .LEVELS (LEVELS),
        .CNT_W  (CNT_W)
    ) u_level_counter (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cnt_req),
        .addr  (cnt_addr),
        .upd   (cnt_upd),
        .value (cnt_value)
    );

    always_comb
    begin
        state_next      = state_reg;
        loaded_next     = loaded_reg;
        remain_next     = remain_reg;
        lvl_next        = lvl_reg;
        src_next        = src_reg;
        pl_b_valid_next = 1'b0;
        p_valid_next    = p_valid_reg;
        p_none_next     = p_none_reg;
        p_end_next      = p_end_reg;
        out_valid_next  = out_valid_reg;

        if (p_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (rd_xfer)
        begin
            p_valid_next = 1'b1;
            p_none_next  = !rd_avail;
            p_end_next   = rd_avail && (remain_reg == CNT_W'(1));
            if (rd_avail)
            begin
                remain_next = rd_pos;
            end
        end
        else if (p_move)
        begin
            p_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT_CLR:
            begin
                lvl_next = lvl_reg + LVL_W'(1);
                if (lvl_last)
                begin
                    lvl_next   = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD, ST_READ:
            begin
                if (ld_xfer)
                begin
                    loaded_next = ld_base + CNT_W'(ld_store);
                    remain_next = '0;
                    lvl_next    = '0;
                    state_next  = s_axis_tlast ? ST_PREFIX : ST_LOAD;
                end
            end
            ST_PREFIX:
            begin
                lvl_next = lvl_reg + LVL_W'(1);
                if (lvl_last)
                begin
                    lvl_next   = '0;
                    src_next   = rd_pos_of_loaded(loaded_reg);
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                pl_b_valid_next = 1'b1;
                src_next        = src_reg - IDX_W'(1);
                if (src_reg == '0)
                begin
                    state_next = ST_SORT_CLR;
                end
            end
            ST_SORT_CLR:
            begin
                if (!pl_b_valid_reg)
                begin
                    lvl_next = lvl_reg + LVL_W'(1);
                    if (lvl_last)
                    begin
                        lvl_next    = '0;
                        remain_next = loaded_reg;
                        state_next  = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_INIT_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT_CLR;
            loaded_reg     <= '0;
            remain_reg     <= '0;
            lvl_reg        <= '0;
            src_reg        <= '0;
            pl_b_valid_reg <= 1'b0;
            p_valid_reg    <= 1'b0;
            p_none_reg     <= 1'b0;
            p_end_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            loaded_reg     <= loaded_next;
            remain_reg     <= remain_next;
            lvl_reg        <= lvl_next;
            src_reg        <= src_next;
            pl_b_valid_reg <= pl_b_valid_next;
            p_valid_reg    <= p_valid_next;
            p_none_reg     <= p_none_next;
            p_end_reg      <= p_end_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_store)
        begin
            rec_mem[ld_base[IDX_W-1:0]] <= {ld_key_sat, ld_tag};
        end
        if (state_reg == ST_PLACE)
        begin
            rec_rdata_reg <= rec_mem[src_reg];
        end
        if (pl_b_valid_reg)
        begin
            pl_c_data_reg <= rec_rdata_reg;
        end
        if (cnt_upd.valid && (cnt_upd.op == CNT_DEC))
        begin
            srt_mem[cnt_value[IDX_W-1:0]] <= pl_c_data_reg;
        end
        if (rd_xfer && rd_avail)
        begin
            srt_rdata_reg <= srt_mem[rd_pos[IDX_W-1:0]];
        end
        if (p_move)
        begin
            out_data_reg <= p_none_reg ? '0 : srt_rdata_reg;
            out_last_reg <= p_end_reg;
            out_none_reg <= p_none_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'(out_data_reg);
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_none_reg;

    `ASSERT_CLK(a_loaded_in_range, loaded_reg <= CNT_W'(RECORDS),
        "record count exceeds the store depth")
    `ASSERT_CLK(a_remain_bounded, remain_reg <= loaded_reg,
        "more records left to read than were loaded")
    `ASSERT_IMPL(a_no_transfer_in_sort,
        (state_reg == ST_PREFIX) || (state_reg == ST_PLACE) || (state_reg == ST_SORT_CLR),
        !s_axis_tready, "input taken while the sort runs")
    `ASSERT_IMPL(a_read_reaches_stage, rd_xfer, ##1 p_valid_reg,
        "accepted read did not produce a pending result")

endmodule

### dv/tb.sv
// Self-checking testbench of counting_sort_descending: loads and reads records over the stream
// ports and checks every result against the expected values of a directed table or against an
// in-bench model of the descending counting sort. Depends on cso_pkg and the block's RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cso_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int TOP_LEVEL     = 3 * GRADE_MAX_DEF;
    localparam int STORE_DEPTH   = RECORDS_DEF;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int HOLD_BATCH    = 40;
    localparam int LONG_HOLD     = 400;
    localparam int STALL_LIMIT   = 20000;
    localparam int TAIL_CYCLES   = 8;
    localparam int DIRECTED_ROWS = 23;

    typedef struct packed {
        logic [TAG_W-1:0] out_tag;
        logic [KEY_W-1:0] out_key;
        logic             end_of_run;
        logic             none_left;
    } sorted_rec_t;

    typedef struct packed {
        logic             cmd;
        logic [KEY_W-1:0] sort_key;
        logic [TAG_W-1:0] record_tag;
        logic             final_record;
        logic             typed;
        sorted_rec_t      want;
    } directed_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;
    logic               s_axis_tlast;
    logic               s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tlast;
    logic               m_axis_tuser;

    logic [KEY_W-1:0] key_mem [STORE_DEPTH];
    logic [TAG_W-1:0] tag_mem [STORE_DEPTH];
    logic [REC_W-1:0] sorted_mem [STORE_DEPTH];
    int               level_tally [0:TOP_LEVEL];
    int               loaded_n;
    int               read_pos;
    bit               reading;

    sorted_rec_t awaited_records [$];
    sorted_rec_t got_rec;
    sorted_rec_t want_rec;

    int failures;
    int load_count;
    int read_count;
    int sort_count;
    int checked_count;
    int idle_cycles;
    int rx_stall_left;
    bit hold_request;
    bit rx_stalls_on;
    bit gaps_on;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_READ, 9'd0,   12'h000, 1'b0, 1'b1, '{12'h000, 9'd0,   1'b0, 1'b1}},
        '{CMD_LOAD, 9'd0,   12'h000, 1'b0, 1'b0, '0},
        '{CMD_LOAD, 9'd300, 12'hFFF, 1'b0, 1'b0, '0},
        '{CMD_LOAD, 9'd511, 12'hABC, 1'b0, 1'b0, '0},
        '{CMD_LOAD, 9'd301, 12'h555, 1'b0, 1'b0, '0},
        '{CMD_LOAD, 9'd150, 12'h2AA, 1'b0, 1'b0, '0},
        '{CMD_LOAD, 9'd0,   12'hFFF, 1'b1, 1'b0, '0},
        '{CMD_READ, 9'd0,   12'h000, 1'b0, 1'b1, '{12'h555, 9'd300, 1'b0, 1'b0}},
        '{CMD_READ, 9'd0,   12'h000, 1'b0, 1'b1, '{12'hABC, 9'd300, 1'b0, 1'b0}},
        '{CMD_READ, 9'd0,   12'h000, 1'b0, 1'b1, '{12'hFFF, 9'd300, 1'b0, 1'b0}},
        '{CMD_READ, 9'd0,   12'h000, 1'b0, 1'b0, '0},
        '{CMD_READ, 9'd0,   12'h000, 1'b0, 1'b0, '0},
        '{CMD_READ, 9'd0,   12'h000, 1'b0, 1'b1, '{12'h000, 9'd0,   1'b1, 1'b0}},
        '{CMD_READ, 9'd0,   12'h000, 1'b0, 1'b1, '{12'h000, 9'd0,   1'b0, 1'b1}},
        '{CMD_LOAD, 9'd200, 12'h123, 1'b0, 1'b0, '0},
        '{CMD_LOAD, 9'd100, 12'h456, 1'b1, 1'b0, '0},
        '{CMD_READ, 9'd0,   12'h000, 1'b0, 1'b0, '0},
        '{CMD_LOAD, 9'd50,  12'h789, 1'b0, 1'b0, '0},
        '{CMD_READ, 9'd0,   12'h000, 1'b0, 1'b1, '{12'h000, 9'd0,   1'b0, 1'b1}},
        '{CMD_LOAD, 9'd511, 12'h000, 1'b1, 1'b0, '0},
        '{CMD_READ, 9'd0,   12'h000, 1'b0, 1'b1, '{12'h000, 9'd300, 1'b0, 1'b0}},
        '{CMD_READ, 9'd0,   12'h000, 1'b0, 1'b0, '0},
        '{CMD_READ, 9'd0,   12'h000, 1'b0, 1'b1, '{12'h000, 9'd0,   1'b0, 1'b1}}
    };

    counting_sort_descending i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(HALF_PERIOD) clk = ~clk;

    task automatic order_batch();
        int i;
        logic [KEY_W-1:0] k;
        for (i = 0; i <= TOP_LEVEL; i++)
            level_tally[i] = 0;
        for (i = 0; i < loaded_n; i++)
            level_tally[key_mem[i]]++;
        for (i = 1; i <= TOP_LEVEL; i++)
            level_tally[i] += level_tally[i - 1];
        for (i = loaded_n; i > 0; i--)
        begin
            k = key_mem[i - 1];
            level_tally[k]--;
            sorted_mem[level_tally[k]] = {k, tag_mem[i - 1]};
        end
        read_pos = 0;
        reading = 1'b1;
        sort_count++;
    endtask

    task automatic apply_command(input logic cmd, input logic [KEY_W-1:0] sort_key,
                                 input logic [TAG_W-1:0] record_tag, input logic final_record,
                                 output sorted_rec_t pred, output bit has_pred);
        logic [KEY_W-1:0] k;
        int idx;
        pred = '0;
        pred.none_left = 1'b1;
        has_pred = 1'b0;
        if (cmd == CMD_LOAD)
        begin
            if (reading)
            begin
                reading = 1'b0;
                loaded_n = 0;
                read_pos = 0;
            end
            k = (sort_key > TOP_LEVEL) ? KEY_W'(TOP_LEVEL) : sort_key;
            if (loaded_n < STORE_DEPTH)
            begin
                key_mem[loaded_n] = k;
                tag_mem[loaded_n] = record_tag;
                loaded_n++;
            end
            if (final_record)
                order_batch();
        end
        else
        begin
            has_pred = 1'b1;
            if (reading && read_pos < loaded_n)
            begin
                idx = loaded_n - 1 - read_pos;
                pred.out_tag = sorted_mem[idx][TAG_W-1:0];
                pred.out_key = sorted_mem[idx][REC_W-1:TAG_W];
                pred.end_of_run = (read_pos + 1 == loaded_n);
                pred.none_left = 1'b0;
                read_pos++;
            end
        end
    endtask

    task automatic transfer_item(input logic cmd, input logic [KEY_W-1:0] sort_key,
                                 input logic [TAG_W-1:0] record_tag, input logic final_record,
                                 input bit typed, input sorted_rec_t want);
        sorted_rec_t pred;
        bit has_pred;
        @(negedge clk);
        s_axis_tuser = cmd;
        s_axis_tdata = {{(TDATA_W - REC_W){1'b0}}, record_tag, sort_key};
        s_axis_tlast = final_record;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        apply_command(cmd, sort_key, record_tag, final_record, pred, has_pred);
        if (has_pred)
        begin
            awaited_records.push_back(typed ? want : pred);
            read_count++;
        end
        else
            load_count++;
    endtask

    task automatic pause_input(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
        end
    endtask

    task automatic random_gap();
        if (gaps_on && $urandom_range(0, 5) == 0)
            pause_input($urandom_range(1, 13));
    endtask

    task automatic drain_results();
        pause_input(1);
        while (awaited_records.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_read();
        transfer_item(CMD_READ, KEY_W'($urandom), TAG_W'($urandom),
                      $urandom_range(0, 15) == 0, 1'b0, '0);
    endtask

    function automatic logic [KEY_W-1:0] draw_key(input bit narrow, input int base);
        if ($urandom_range(0, 9) == 0)
            return KEY_W'($urandom_range(TOP_LEVEL + 1, (1 << KEY_W) - 1));
        if (narrow)
            return KEY_W'(base + $urandom_range(0, 3));
        return KEY_W'($urandom_range(0, TOP_LEVEL));
    endfunction

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_rec.out_tag = m_axis_tdata[TAG_W-1:0];
            got_rec.out_key = m_axis_tdata[REC_W-1:TAG_W];
            got_rec.end_of_run = m_axis_tlast;
            got_rec.none_left = m_axis_tuser;
            if (awaited_records.size() == 0)
            begin
                $error("result transfer with no read waiting: tag %0d key %0d",
                       got_rec.out_tag, got_rec.out_key);
                failures++;
            end
            else
            begin
                want_rec = awaited_records.pop_front();
                report_field("out_tag", want_rec.out_tag, got_rec.out_tag);
                report_field("out_key", want_rec.out_key, got_rec.out_key);
                report_field("end_of_run", want_rec.end_of_run, got_rec.end_of_run);
                report_field("none_left", want_rec.none_left, got_rec.none_left);
                checked_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles.", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        m_axis_tready = 1'b0;
        rx_stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                m_axis_tready = 1'b0;
            else if (hold_request)
            begin
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD - 1)
                    @(negedge clk);
                hold_request = 1'b0;
            end
            else if (rx_stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                rx_stall_left--;
            end
            else if (rx_stalls_on && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready = 1'b0;
                rx_stall_left = $urandom_range(0, 12);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    initial
    begin
        int row;
        int j;
        int n;
        int reads;
        int base;
        int batch;
        int random_items;
        bit narrow;
        bit fin_missing;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        s_axis_tuser = CMD_LOAD;
        hold_request = 1'b0;
        rx_stalls_on = 1'b0;
        gaps_on = 1'b0;
        failures = 0;
        load_count = 0;
        read_count = 0;
        sort_count = 0;
        checked_count = 0;
        loaded_n = 0;
        read_pos = 0;
        reading = 1'b0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            transfer_item(directed_rows[row].cmd, directed_rows[row].sort_key,
                          directed_rows[row].record_tag, directed_rows[row].final_record,
                          directed_rows[row].typed, directed_rows[row].want);
            random_gap();
        end

        // Read one batch back while the receiver holds off, so the result path fills up.
        for (j = 0; j < HOLD_BATCH; j++)
        begin
            transfer_item(CMD_LOAD, draw_key(1'b0, 0), TAG_W'($urandom),
                          j == HOLD_BATCH - 1, 1'b0, '0);
            random_gap();
        end
        random_read();
        hold_request = 1'b1;
        for (j = 1; j < HOLD_BATCH + 2; j++)
        begin
            random_read();
            random_gap();
        end
        drain_results();

        random_items = 0;
        batch = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items > RANDOM_ITEMS * 4 / 5)
            begin
                gaps_on = 1'b0;
                rx_stalls_on = 1'b0;
            end
            else
            begin
                gaps_on = $urandom_range(0, 3) != 0;
                rx_stalls_on = $urandom_range(0, 3) != 0;
            end
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(150, 400) : $urandom_range(1, 30);
            narrow = $urandom_range(0, 2) == 0;
            base = $urandom_range(0, TOP_LEVEL - 3);
            fin_missing = $urandom_range(0, 14) == 0;
            for (j = 0; j < n; j++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    random_read();
                    random_items++;
                end
                transfer_item(CMD_LOAD, draw_key(narrow, base), TAG_W'($urandom),
                              (j == n - 1) && !fin_missing, 1'b0, '0);
                random_items++;
                random_gap();
            end
            if (!fin_missing)
            begin
                reads = ($urandom_range(0, 4) == 0) ? $urandom_range(1, loaded_n)
                                                     : loaded_n + $urandom_range(0, 2);
                for (j = 0; j < reads; j++)
                begin
                    random_read();
                    random_items++;
                    random_gap();
                end
            end
            if (gaps_on && (batch % 8 == 3))
                drain_results();
            batch++;
        end

        drain_results();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        $display("Covered %0d load and %0d read transfers over %0d sort runs,", load_count,
                 read_count, sort_count);
        $display("including a long receiver hold and reads past the end; %0d results checked.",
                 checked_count);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/cso_pkg.sv
rtl/core/cso_level_counter.sv
rtl/core/counting_sort_descending.sv
dv/tb.sv
